/* sv/scds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scds_pkg
// Shared types and constants for the serial clock divider search block.
// ----------------------------------------------------------------------------
package scds_pkg;

  localparam int unsigned CLK_W    = 30;  // system clock / rate width
  localparam int unsigned FREQ_W   = 32;  // target rate width
  localparam int unsigned PRE_W    = 13;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned PROD_W   = 20;  // (prescale+1)*(count+1) <= 2^19
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIV_CW   = $clog2(CLK_W);
  localparam int unsigned CFG_AW   = 2;

  // slowest rate is clk / (8192*64)
  localparam int unsigned SLOW_SHIFT = 19;
  // prescale candidates are estimate-1 .. estimate+2, estimate = q-1
  localparam logic [CLK_W:0] EST_BIAS = (CLK_W+1)'(2);

  localparam logic [WORD_W-1:0] BYPASS_WORD  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] SLOWEST_WORD = 32'h7FFF_F000;
  localparam logic [PRE_W-1:0]  PRESCALE_MAX = 13'h1FFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = 6'h3F;
  localparam logic [CLK_W-1:0]  SYS_CLK_RST  = 30'd80000000;

  localparam logic [CFG_AW-1:0] ADDR_SYS_CLK = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NDIV,
    ST_NWAIT,
    ST_EDIV,
    ST_EWAIT,
    ST_MUL,
    ST_CDIV,
    ST_CWAIT,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // low[5:0], high[11:6] = 0, count[17:12], prescale[30:18], bypass[31] = 0
  function automatic logic [WORD_W-1:0] pack_word(input logic [PRE_W-1:0] pre,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] low;
    low = ({1'b0, cnt} + (CNT_W+1)'(1)) >> 1;
    return {1'b0, pre, cnt, {CNT_W{1'b0}}, low[CNT_W-1:0]};
  endfunction

endpackage

/* sv/scds_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scds_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scds_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [scds_pkg::CLK_W-1:0]       dividend_i,
  input  logic [scds_pkg::FREQ_W-1:0]      divisor_i,
  output scds_pkg::div_stat_t              stat_o,
  output logic [scds_pkg::CLK_W-1:0]       quotient_o
);

  logic                             active_q, active_d;
  logic                             done_q, done_d;
  logic [scds_pkg::DIV_CW-1:0]      cnt_q, cnt_d;
  logic [scds_pkg::FREQ_W-1:0]      rem_q, rem_d;
  logic [scds_pkg::FREQ_W-1:0]      dvs_q, dvs_d;
  logic [scds_pkg::CLK_W-1:0]       dq_q, dq_d;
  logic [scds_pkg::FREQ_W:0]        trial;
  logic [scds_pkg::FREQ_W:0]        diff;
  logic                             fits;

  assign trial = {rem_q, dq_q[scds_pkg::CLK_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    dq_d     = dq_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = '0;
      dvs_d    = divisor_i;
      dq_d     = dividend_i;
    end else if (active_q) begin
      // dividend bits shift out at the top, quotient bits in at the bottom
      rem_d = fits ? diff[scds_pkg::FREQ_W-1:0] : trial[scds_pkg::FREQ_W-1:0];
      dq_d  = {dq_q[scds_pkg::CLK_W-2:0], fits};
      cnt_d = cnt_q + scds_pkg::DIV_CW'(1);
      if (cnt_q == scds_pkg::DIV_CW'(scds_pkg::CLK_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q;

endmodule

/* sv/scds_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scds_cfg
// APB register slice holding the system clock frequency.
// ----------------------------------------------------------------------------
module scds_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scds_pkg::CFG_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [scds_pkg::CLK_W-1:0]        sys_clock_hz_o
);

  logic [scds_pkg::CLK_W-1:0] sys_clk_q, sys_clk_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == scds_pkg::ADDR_SYS_CLK);

  always_comb begin
    sys_clk_d = sys_clk_q;
    if (wr_en) begin
      sys_clk_d = pwdata[scds_pkg::CLK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_clk_q <= scds_pkg::SYS_CLK_RST;
    end else begin
      sys_clk_q <= sys_clk_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == scds_pkg::ADDR_SYS_CLK) begin
      prdata = {{(32 - scds_pkg::CLK_W){1'b0}}, sys_clk_q};
    end
  end

  assign sys_clock_hz_o = sys_clk_q;

endmodule

/* sv/spi_clock_divider_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_clock_divider_search_core
// Finds a serial clock divider word for a requested rate.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one target rate. busy stays high
// until the result, which appears for a single cycle with done_o high and
// must be captured then. Targets at or above the system clock, or below the
// slowest reachable rate, strobe their result straight from the check state.
// Otherwise the search walks counts 1..63 with four prescale trials each.
// Every division runs through one shared 30-step divider. For each count it
// divides the system clock by count+1 and that quotient by the target, then
// each trial divides the system clock by (prescale+1)*(count+1). An exact
// match ends the search early.
// ----------------------------------------------------------------------------
module spi_clock_divider_search_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [scds_pkg::FREQ_W-1:0]        target_hz_i,
  output logic                               done_o,
  output logic [scds_pkg::WORD_W-1:0]        divider_word_o,
  output logic [scds_pkg::PRE_W-1:0]         prescale_o,
  output logic [scds_pkg::CNT_W-1:0]         n_count_o,
  output logic [scds_pkg::CNT_W-1:0]         low_count_o,
  output logic                               sysclk_bypass_o,
  output logic [scds_pkg::CLK_W-1:0]         achieved_hz_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [scds_pkg::CFG_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  scds_pkg::state_e                  state_q, state_d;
  logic [scds_pkg::CLK_W-1:0]        sys_clk;
  logic [scds_pkg::FREQ_W-1:0]       freq_q;
  logic [scds_pkg::CNT_W-1:0]        n_q;
  logic [1:0]                        k_q;
  logic [scds_pkg::CLK_W-1:0]        q1_q;
  logic [scds_pkg::CLK_W-1:0]        q2_q;
  logic [scds_pkg::PRE_W-1:0]        pre_q;
  logic [scds_pkg::PROD_W-1:0]       prod_q;
  logic [scds_pkg::CLK_W-1:0]        best_rate_q;
  logic [scds_pkg::WORD_W-1:0]       best_word_q;
  logic [scds_pkg::WORD_W-1:0]       word_q;
  logic [scds_pkg::CLK_W-1:0]        ach_q;

  logic                              div_start;
  logic [scds_pkg::CLK_W-1:0]        div_dividend;
  logic [scds_pkg::FREQ_W-1:0]       div_divisor;
  scds_pkg::div_stat_t               div_stat;
  logic [scds_pkg::CLK_W-1:0]        div_q;

  logic [scds_pkg::CLK_W:0]          est_sum;
  logic [scds_pkg::CLK_W:0]          est_sub;
  logic [scds_pkg::PRE_W-1:0]        pre_c;
  logic [scds_pkg::PRE_W+scds_pkg::CNT_W+1:0] prod_c;
  logic [scds_pkg::WORD_W-1:0]       cand_word;
  logic                              exact;
  logic                              better;
  logic                              last_trial;
  logic [scds_pkg::CLK_W-1:0]        nbest_rate;
  logic [scds_pkg::WORD_W-1:0]       nbest_word;
  logic                              is_bypass;
  logic                              is_slowest;
  logic [scds_pkg::CLK_W-1:0]        slow_rate;

  scds_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sys_clock_hz_o (sys_clk)
  );

  scds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  // ---------------- candidate arithmetic ----------------
  assign slow_rate  = sys_clk >> scds_pkg::SLOW_SHIFT;
  assign is_bypass  = freq_q >= {{(scds_pkg::FREQ_W - scds_pkg::CLK_W){1'b0}}, sys_clk};
  assign is_slowest = (freq_q == '0) ||
                      (freq_q < {{(scds_pkg::FREQ_W - scds_pkg::CLK_W){1'b0}}, slow_rate});

  // prescale = q2 - 2 + k, clamped to 0..8191
  assign est_sum = {1'b0, q2_q} + {{(scds_pkg::CLK_W - 1){1'b0}}, k_q};
  assign est_sub = est_sum - scds_pkg::EST_BIAS;

  always_comb begin
    if (est_sum < scds_pkg::EST_BIAS) begin
      pre_c = '0;
    end else if (est_sub > {{(scds_pkg::CLK_W + 1 - scds_pkg::PRE_W){1'b0}},
                           scds_pkg::PRESCALE_MAX}) begin
      pre_c = scds_pkg::PRESCALE_MAX;
    end else begin
      pre_c = est_sub[scds_pkg::PRE_W-1:0];
    end
  end

  assign prod_c = ({1'b0, pre_c} + (scds_pkg::PRE_W+1)'(1)) *
                  ({1'b0, n_q} + (scds_pkg::CNT_W+1)'(1));

  assign cand_word  = scds_pkg::pack_word(pre_q, n_q);
  assign exact      = {{(scds_pkg::FREQ_W - scds_pkg::CLK_W){1'b0}}, div_q} == freq_q;
  assign better     = ({{(scds_pkg::FREQ_W - scds_pkg::CLK_W){1'b0}}, div_q} < freq_q) &&
                      (div_q > best_rate_q);
  assign last_trial = (k_q == 2'd3) && (n_q == scds_pkg::COUNT_MAX);
  assign nbest_rate = better ? div_q : best_rate_q;
  assign nbest_word = better ? cand_word : best_word_q;

  // ---------------- divider operand select ----------------
  always_comb begin
    div_dividend = sys_clk;
    div_divisor  = {{(scds_pkg::FREQ_W - scds_pkg::PROD_W){1'b0}}, prod_q};
    case (state_q)
      scds_pkg::ST_NDIV: begin
        div_divisor = scds_pkg::FREQ_W'({1'b0, n_q} + (scds_pkg::CNT_W+1)'(1));
      end
      scds_pkg::ST_EDIV: begin
        div_dividend = q1_q;
        div_divisor  = freq_q;
      end
      default: begin
      end
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      scds_pkg::ST_IDLE:  if (start) state_d = scds_pkg::ST_CHECK;
      scds_pkg::ST_CHECK: begin
        if (is_bypass || is_slowest) state_d = scds_pkg::ST_DONE;
        else                         state_d = scds_pkg::ST_NDIV;
      end
      scds_pkg::ST_NDIV:  state_d = scds_pkg::ST_NWAIT;
      scds_pkg::ST_NWAIT: if (div_stat.done) state_d = scds_pkg::ST_EDIV;
      scds_pkg::ST_EDIV:  state_d = scds_pkg::ST_EWAIT;
      scds_pkg::ST_EWAIT: if (div_stat.done) state_d = scds_pkg::ST_MUL;
      scds_pkg::ST_MUL:   state_d = scds_pkg::ST_CDIV;
      scds_pkg::ST_CDIV:  state_d = scds_pkg::ST_CWAIT;
      scds_pkg::ST_CWAIT: if (div_stat.done) state_d = scds_pkg::ST_EVAL;
      scds_pkg::ST_EVAL: begin
        if (exact || last_trial) state_d = scds_pkg::ST_DONE;
        else if (k_q == 2'd3)    state_d = scds_pkg::ST_NDIV;
        else                     state_d = scds_pkg::ST_MUL;
      end
      scds_pkg::ST_DONE:  state_d = scds_pkg::ST_IDLE;
      default:            state_d = scds_pkg::ST_IDLE;
    endcase
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    busy      = 1'b1;
    done_o    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      scds_pkg::ST_IDLE: busy = 1'b0;
      scds_pkg::ST_NDIV,
      scds_pkg::ST_EDIV,
      scds_pkg::ST_CDIV: div_start = 1'b1;
      scds_pkg::ST_DONE: done_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      scds_pkg::ST_IDLE: begin
        if (start) freq_q <= target_hz_i;
      end
      scds_pkg::ST_CHECK: begin
        n_q         <= scds_pkg::CNT_W'(1);
        k_q         <= '0;
        best_rate_q <= '0;
        best_word_q <= '0;
        if (is_bypass) begin
          word_q <= scds_pkg::BYPASS_WORD;
          ach_q  <= sys_clk;
        end else begin
          word_q <= scds_pkg::SLOWEST_WORD;
          ach_q  <= slow_rate;
        end
      end
      scds_pkg::ST_NWAIT: begin
        if (div_stat.done) q1_q <= div_q;
      end
      scds_pkg::ST_EWAIT: begin
        if (div_stat.done) q2_q <= div_q;
      end
      scds_pkg::ST_MUL: begin
        pre_q  <= pre_c;
        prod_q <= prod_c[scds_pkg::PROD_W-1:0];
      end
      scds_pkg::ST_EVAL: begin
        best_rate_q <= nbest_rate;
        best_word_q <= nbest_word;
        k_q         <= k_q + 2'd1;
        if (k_q == 2'd3) n_q <= n_q + scds_pkg::CNT_W'(1);
        if (exact) begin
          word_q <= cand_word;
          ach_q  <= div_q;
        end else if (nbest_rate == '0) begin
          // nothing below the target: empty word, rate as if undivided
          word_q <= '0;
          ach_q  <= sys_clk;
        end else begin
          word_q <= nbest_word;
          ach_q  <= nbest_rate;
        end
      end
      default: begin
      end
    endcase
  end

  assign divider_word_o  = word_q;
  assign prescale_o      = word_q[30:18];
  assign n_count_o       = word_q[17:12];
  assign low_count_o     = word_q[5:0];
  assign sysclk_bypass_o = word_q[31];
  assign achieved_hz_o   = ach_q;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while running");

  a_bypass_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && sysclk_bypass_o |-> achieved_hz_o == sys_clk)
    else $error("bypass result with wrong rate");

  a_search_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !sysclk_bypass_o && (divider_word_o != scds_pkg::SLOWEST_WORD) &&
    (divider_word_o != '0) |->
    {{(scds_pkg::FREQ_W - scds_pkg::CLK_W){1'b0}}, achieved_hz_o} <= freq_q)
    else $error("searched rate above target");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial clock divider search core. Targets go in
// through the start/busy command port and results are caught on the done_o
// strobe. Each one is checked field by field against an in-bench search of
// the divider word. The system clock register is programmed over the APB
// port and read back between phases, at 1 Hz, 1 GHz and random values.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned     HALF_PERIOD      = 5;
  localparam int unsigned     RESET_CYCLES     = 9;
  localparam int unsigned     NUM_PHASES       = 5;
  localparam int unsigned     DIRECTED_PHASES  = 3;
  localparam int unsigned     RANDOM_PER_PHASE = 20;
  localparam int unsigned     SETTLE_CYCLES    = 40;
  localparam longint unsigned TIMEOUT_NS       = 80_000_000;
  localparam longint          PRE_TOP          = scds_pkg::PRESCALE_MAX;
  localparam int unsigned     CLK_HZ_MAX       = 1_000_000_000;
  localparam int unsigned     SMALL_CLK_MAX    = 1000;

  typedef struct packed {
    logic [scds_pkg::WORD_W-1:0] word;
    logic [scds_pkg::PRE_W-1:0]  prescale;
    logic [scds_pkg::CNT_W-1:0]  n_count;
    logic [scds_pkg::CNT_W-1:0]  low_count;
    logic                        bypass;
    logic [scds_pkg::CLK_W-1:0]  rate;
  } divider_result_t;

  typedef struct packed {
    logic [scds_pkg::FREQ_W-1:0] target;
    divider_result_t             res;
  } divider_request_t;

  // Holds the register copy and the expected divider words in arrival order.
  class divider_ledger;
    logic [scds_pkg::CLK_W-1:0] sys_clock_hz;
    divider_request_t pending_words[$];
    int unsigned      errors;
    string            ctx;

    function new();
      sys_clock_hz = scds_pkg::SYS_CLK_RST;
      errors = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    function logic [scds_pkg::WORD_W-1:0] search_divider(input longint unsigned clk,
                                                         input longint unsigned freq);
      logic [scds_pkg::WORD_W-1:0] best;
      logic [scds_pkg::WORD_W-1:0] word;
      longint unsigned   best_rate;
      longint unsigned   rate;
      longint unsigned   pre;
      longint            est;
      longint            trial;
      int                low_phase;
      best = '0;
      best_rate = 0;
      if (freq >= clk) return scds_pkg::BYPASS_WORD;
      if (freq == 0 || freq < (clk >> scds_pkg::SLOW_SHIFT)) return scds_pkg::SLOWEST_WORD;
      for (int n = 1; n <= scds_pkg::COUNT_MAX; n++) begin
        est = (clk / (n + 1)) / freq;
        est = est - 1;
        low_phase = (n + 1) / 2;
        for (int off = -1; off <= 2; off++) begin
          trial = est + off;
          if (trial > PRE_TOP) begin
            trial = PRE_TOP;
          end else if (trial < 0) begin
            trial = 0;
          end
          pre = trial;
          word = {1'b0, pre[scds_pkg::PRE_W-1:0], n[scds_pkg::CNT_W-1:0],
                  {scds_pkg::CNT_W{1'b0}}, low_phase[scds_pkg::CNT_W-1:0]};
          rate = clk / ((pre + 1) * (n + 1));
          if (rate == freq) return word;
          // keep the earliest of the fastest rates under the target
          if (rate < freq && rate > best_rate) begin
            best_rate = rate;
            best = word;
          end
        end
      end
      return best;
    endfunction

    task note_target(input logic [scds_pkg::FREQ_W-1:0] target);
      divider_request_t want;
      longint unsigned  pre;
      longint unsigned  cnt;
      longint unsigned  rate;
      want.target = target;
      want.res.word = search_divider(sys_clock_hz, target);
      want.res.prescale = want.res.word[scds_pkg::WORD_W-2 -: scds_pkg::PRE_W];
      want.res.n_count = want.res.word[2*scds_pkg::CNT_W +: scds_pkg::CNT_W];
      want.res.low_count = want.res.word[scds_pkg::CNT_W-1:0];
      want.res.bypass = want.res.word[scds_pkg::WORD_W-1];
      pre = want.res.prescale;
      cnt = want.res.n_count;
      rate = sys_clock_hz / ((pre + 1) * (cnt + 1));
      want.res.rate = rate[scds_pkg::CLK_W-1:0];
      pending_words.push_back(want);
    endtask

    task check_field(input string name, input logic [63:0] got,
                     input logic [63:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("%s %s: got 0x%0h, expected 0x%0h",
                                ctx, name, got, want));
      end
    endtask

    task check_result(input divider_result_t got);
      divider_request_t want;
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word 0x%08h", got.word));
        return;
      end
      want = pending_words.pop_front();
      ctx = $sformatf("target %0d clk %0d", want.target, sys_clock_hz);
      check_field("divider_word", got.word, want.res.word);
      check_field("prescale", got.prescale, want.res.prescale);
      check_field("n_count", got.n_count, want.res.n_count);
      check_field("low_count", got.low_count, want.res.low_count);
      check_field("sysclk_bypass", got.bypass, want.res.bypass);
      check_field("achieved_hz", got.rate, want.res.rate);
    endtask

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [scds_pkg::FREQ_W-1:0]   target_hz_i;
  logic                          done_o;
  logic [scds_pkg::WORD_W-1:0]   divider_word_o;
  logic [scds_pkg::PRE_W-1:0]    prescale_o;
  logic [scds_pkg::CNT_W-1:0]    n_count_o;
  logic [scds_pkg::CNT_W-1:0]    low_count_o;
  logic                          sysclk_bypass_o;
  logic [scds_pkg::CLK_W-1:0]    achieved_hz_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [scds_pkg::CFG_AW-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  divider_ledger ledger;

  spi_clock_divider_search_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .target_hz_i    (target_hz_i),
    .done_o         (done_o),
    .divider_word_o (divider_word_o),
    .prescale_o     (prescale_o),
    .n_count_o      (n_count_o),
    .low_count_o    (low_count_o),
    .sysclk_bypass_o(sysclk_bypass_o),
    .achieved_hz_o  (achieved_hz_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin : result_monitor
    divider_result_t got;
    if (rst_ni && done_o) begin
      got.word = divider_word_o;
      got.prescale = prescale_o;
      got.n_count = n_count_o;
      got.low_count = low_count_o;
      got.bypass = sysclk_bypass_o;
      got.rate = achieved_hz_o;
      ledger.check_result(got);
    end
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  function automatic logic [scds_pkg::FREQ_W-1:0] rand_target(
      input logic [scds_pkg::CLK_W-1:0] clk);
    int unsigned pick;
    int unsigned floor_hz;
    int unsigned pre;
    int unsigned cnt;
    logic [scds_pkg::FREQ_W-1:0] t;
    floor_hz = clk >> scds_pkg::SLOW_SHIFT;
    pick = $urandom_range(0, 99);
    if (pick < 12) return $urandom_range(32'hFFFF_FFFF, clk);
    if (pick < 20) return (floor_hz == 0) ? 0 : $urandom_range(0, floor_hz - 1);
    if (pick < 55) begin
      // reachable rate: if nonzero, the search should land on an exact match
      pre = ($urandom_range(0, 3) == 0) ? $urandom_range(0, scds_pkg::PRESCALE_MAX)
                                        : $urandom_range(0, 31);
      cnt = $urandom_range(1, scds_pkg::COUNT_MAX);
      return clk / ((pre + 1) * (cnt + 1));
    end
    if (clk < 2) return 0;
    t = $urandom_range(clk - 1, floor_hz);
    return t >> $urandom_range(0, 12);
  endfunction

  task automatic apb_access(input logic wr, input logic [scds_pkg::CFG_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_sys_clock();
    logic [31:0] rd;
    apb_access(1'b0, scds_pkg::ADDR_SYS_CLK, '0, rd);
    if (rd !== 32'(ledger.sys_clock_hz)) begin
      ledger.flag_mismatch($sformatf("sys_clock_hz read 0x%08h, expected 0x%08h",
                                     rd, 32'(ledger.sys_clock_hz)));
    end
  endtask

  task automatic program_sys_clock(input logic [31:0] value);
    logic [31:0] unused_rd;
    apb_access(1'b1, scds_pkg::ADDR_SYS_CLK, value, unused_rd);
    ledger.sys_clock_hz = value[scds_pkg::CLK_W-1:0];
    check_sys_clock();
  endtask

  // start stays high across back-to-back items
  task automatic send_target(input logic [scds_pkg::FREQ_W-1:0] value);
    int unsigned gap;
    start <= 1'b1;
    target_hz_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    ledger.note_target(value);
    gap = idle_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0]                 clk_plan [NUM_PHASES];
    logic [scds_pkg::FREQ_W-1:0] corner_targets [8];
    logic [scds_pkg::FREQ_W-1:0] c;
    logic [scds_pkg::FREQ_W-1:0] floor_hz;
    rst_ni <= 1'b0;
    start <= 1'b0;
    target_hz_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= scds_pkg::ADDR_SYS_CLK;
    pwdata <= '0;
    ledger = new();
    clk_plan[0] = scds_pkg::SYS_CLK_RST;
    clk_plan[1] = CLK_HZ_MAX;
    clk_plan[2] = 1;
    clk_plan[3] = $urandom_range(2, SMALL_CLK_MAX);
    clk_plan[4] = $urandom_range(1, CLK_HZ_MAX);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_sys_clock();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // phase 0 runs on the reset value of the register
      if (phase != 0) begin
        drain();
        program_sys_clock(clk_plan[phase]);
      end
      if (phase < DIRECTED_PHASES) begin
        c = ledger.sys_clock_hz;
        floor_hz = c >> scds_pkg::SLOW_SHIFT;
        corner_targets = '{0, 32'hFFFF_FFFF, c, c - 1, floor_hz, floor_hz - 1,
                           c / 2, c / 7};
        foreach (corner_targets[k]) send_target(corner_targets[k]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 1 && i == RANDOM_PER_PHASE / 2) drain();
        send_target(rand_target(ledger.sys_clock_hz));
      end
    end

    drain();
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* spi_clock_divider_search_core.f */
sv/scds_pkg.sv
sv/scds_div.sv
sv/scds_cfg.sv
sv/spi_clock_divider_search_core.sv
tb/sv/tb.sv
